/* hdl/ipv6txt_pkg.sv */
// ipv6txt_pkg: shared types, constants and the hex digit table for the
// ipv6 address to text formatter. no dependencies.
`timescale 1ns / 1ps

package ipv6txt_pkg;

  localparam int unsigned HALF_W  = 64;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned GRP_W   = 16;
  localparam int unsigned N_GRP   = 8;
  localparam int unsigned GIDX_W  = 3;
  localparam int unsigned RUN_W   = 4;

  // run start code meaning no compressed run
  localparam logic [RUN_W-1:0]  RUN_NONE = 4'd8;
  localparam logic [RUN_W-1:0]  RUN_MIN  = 4'd2;
  localparam logic [CHAR_W-1:0] CH_COLON = 7'h3a;

  typedef logic [N_GRP-1:0][GRP_W-1:0] grp_vec_t;

  // classified address: groups plus the chosen zero run
  typedef struct packed {
    grp_vec_t         grp;
    logic [RUN_W-1:0] run_start;
    logic [RUN_W-1:0] run_len;
  } desc_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] c;
    unique case (nib)
      4'h0: c = 7'h30;
      4'h1: c = 7'h31;
      4'h2: c = 7'h32;
      4'h3: c = 7'h33;
      4'h4: c = 7'h34;
      4'h5: c = 7'h35;
      4'h6: c = 7'h36;
      4'h7: c = 7'h37;
      4'h8: c = 7'h38;
      4'h9: c = 7'h39;
      4'ha: c = 7'h61;
      4'hb: c = 7'h62;
      4'hc: c = 7'h63;
      4'hd: c = 7'h64;
      4'he: c = 7'h65;
      default: c = 7'h66;
    endcase
    return c;
  endfunction

endpackage

/* hdl/ipv6txt_if.sv */
// ipv6txt_if: valid/ready channel interfaces for addresses and characters
// depends on ipv6txt_pkg
`timescale 1ns / 1ps

interface ipv6txt_addr_if import ipv6txt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] addr_high;
  logic [HALF_W-1:0] addr_low;

  modport source (output valid, output addr_high, output addr_low, input ready);
  modport sink   (input valid, input addr_high, input addr_low, output ready);
endinterface

interface ipv6txt_char_if import ipv6txt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              is_last;

  modport source (output valid, output out_char, output is_last, input ready);
  modport sink   (input valid, input out_char, input is_last, output ready);
endinterface

/* hdl/ipv6txt_front.sv */
// ipv6txt_front: accepts address beats, splits groups and finds the
// longest zero run; one register stage. depends on ipv6txt_pkg
`timescale 1ns / 1ps

module ipv6txt_front import ipv6txt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [HALF_W-1:0] in_addr_high,
  input  logic [HALF_W-1:0] in_addr_low,
  output logic              push_valid,
  input  logic              push_ready,
  output desc_t             push_desc
);

  logic     v_r;
  desc_t    desc_r;
  desc_t    desc_nxt;
  grp_vec_t grp;

  // group 0 in the top bits of the high half
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      grp[i]     = in_addr_high[HALF_W-GRP_W*(i+1) +: GRP_W];
      grp[i + 4] = in_addr_low[HALF_W-GRP_W*(i+1) +: GRP_W];
    end
  end

  // longest zero run, earliest wins a tie
  always_comb begin
    logic [RUN_W-1:0] cur_start;
    logic [RUN_W-1:0] cur_len;
    logic [RUN_W-1:0] best_start;
    logic [RUN_W-1:0] best_len;
    cur_start  = RUN_NONE;
    cur_len    = '0;
    best_start = RUN_NONE;
    best_len   = '0;
    for (int i = 0; i < N_GRP; i++) begin
      if (grp[i] == '0) begin
        if (cur_len == '0) begin
          cur_start = RUN_W'(i);
        end
        cur_len = cur_len + 1'b1;
        if (cur_len > best_len) begin
          best_start = cur_start;
          best_len   = cur_len;
        end
      end else begin
        cur_len = '0;
      end
    end
    desc_nxt.grp       = grp;
    desc_nxt.run_start = (best_len < RUN_MIN) ? RUN_NONE : best_start;
    desc_nxt.run_len   = best_len;
  end

  assign in_ready   = !v_r || push_ready;
  assign push_valid = v_r;
  assign push_desc  = desc_r;

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      v_r <= 1'b1;
    end else if (push_ready) begin
      v_r <= 1'b0;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      desc_r <= desc_nxt;
    end
  end

endmodule

/* hdl/ipv6txt_fifo.sv */
// ipv6txt_fifo: short queue of classified addresses between front and back
// depends on ipv6txt_pkg
`timescale 1ns / 1ps

module ipv6txt_fifo import ipv6txt_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  desc_t push_desc,
  output logic  pop_valid,
  input  logic  pop,
  output desc_t pop_desc
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  desc_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (cnt_r != CNT_FULL);
  assign pop_valid  = (cnt_r != '0);
  assign pop_desc   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

/* hdl/ipv6txt_back.sv */
// ipv6txt_back: character sequencer, walks groups of the queue head and
// emits one character per beat into an output register. depends on ipv6txt_pkg
`timescale 1ns / 1ps

module ipv6txt_back import ipv6txt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  desc_t             head,
  output logic              head_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last
);

  localparam logic [1:0] ST_START = 2'd0;
  localparam logic [1:0] ST_GROUP = 2'd1;
  localparam logic [1:0] ST_COLON = 2'd2;
  localparam logic [1:0] ST_RUN   = 2'd3;

  localparam logic [GIDX_W-1:0] G_LAST = 3'd7;

  logic [1:0]        st_r,    st_nxt;
  logic [GIDX_W-1:0] g_r,     g_nxt;
  logic [1:0]        d_r,     d_nxt;
  logic              fresh_r, fresh_nxt;
  logic              ov_r;
  logic [CHAR_W-1:0] och_r;
  logic              olast_r;

  logic              adv;
  logic [CHAR_W-1:0] ch;
  logic              last;
  logic [GRP_W-1:0]  cur;
  logic [1:0]        lead;
  logic [1:0]        d_eff;
  logic [RUN_W-1:0]  g_inc;
  logic [RUN_W-1:0]  g_after_run;

  assign adv = head_valid && (!ov_r || out_ready);
  assign cur = head.grp[g_r];
  assign g_inc       = {1'b0, g_r} + 1'b1;
  assign g_after_run = head.run_start + head.run_len;

  // highest non-zero nibble, digit 0 for a zero group
  always_comb begin
    priority if (cur[15:12] != '0) lead = 2'd3;
    else if (cur[11:8] != '0)      lead = 2'd2;
    else if (cur[7:4] != '0)       lead = 2'd1;
    else                           lead = 2'd0;
  end

  // next character and sequencer step
  always_comb begin
    st_nxt    = st_r;
    g_nxt     = g_r;
    d_nxt     = d_r;
    fresh_nxt = fresh_r;
    ch        = CH_COLON;
    last      = 1'b0;
    d_eff     = (st_r == ST_START || fresh_r) ? lead : d_r;
    unique case (st_r)
      ST_START, ST_GROUP: begin
        if (st_r == ST_START && head.run_start == '0) begin
          // run at the front: leading colon, then the run itself
          st_nxt = ST_RUN;
        end else begin
          ch = hex_char(cur[4*d_eff +: 4]);
          if (d_eff == '0) begin
            if (g_r == G_LAST) begin
              last   = 1'b1;
              st_nxt = ST_START;
              g_nxt  = '0;
            end else begin
              st_nxt = ST_COLON;
            end
          end else begin
            d_nxt     = d_eff - 1'b1;
            fresh_nxt = 1'b0;
            st_nxt    = ST_GROUP;
          end
        end
      end
      ST_COLON: begin
        g_nxt     = g_inc[GIDX_W-1:0];
        fresh_nxt = 1'b1;
        st_nxt    = (g_inc == head.run_start) ? ST_RUN : ST_GROUP;
      end
      ST_RUN: begin
        fresh_nxt = 1'b1;
        if (g_after_run[GIDX_W]) begin
          last   = 1'b1;
          st_nxt = ST_START;
          g_nxt  = '0;
        end else begin
          st_nxt = ST_GROUP;
          g_nxt  = g_after_run[GIDX_W-1:0];
        end
      end
      default: begin
        st_nxt = ST_START;
      end
    endcase
  end

  assign head_pop  = adv && last;
  assign out_valid = ov_r;
  assign out_char  = och_r;
  assign out_last  = olast_r;

  // sequencer state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_START;
      g_r     <= '0;
      d_r     <= '0;
      fresh_r <= 1'b1;
      ov_r    <= 1'b0;
    end else if (adv) begin
      st_r    <= st_nxt;
      g_r     <= g_nxt;
      d_r     <= d_nxt;
      fresh_r <= fresh_nxt;
      ov_r    <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  // output beat payload
  always_ff @(posedge clk) begin
    if (adv) begin
      och_r   <= ch;
      olast_r <= last;
    end
  end

endmodule

/* hdl/ipv6_address_to_text_top.sv */
// ipv6_address_to_text_top: ipv6 address to compressed text, top level
// depends on ipv6txt_pkg, ipv6txt_if, ipv6txt_front, ipv6txt_fifo, ipv6txt_back
//
//  channel   dir  payload                          beat
//  in_chan   in   addr_high[63:0], addr_low[63:0]  one address
//  out_chan  out  out_char[6:0], is_last           one character
//
// an address occupies the character sequencer for as many output beats as its
// text has characters, 2 to 39; that sequencer sets the sustained rate.
// an input beat passes the front stage register, a queue entry and the output register.
// reset clears the front stage, queue count and sequencer; payload is not reset.
// out_chan.ready low holds the output register; the front stage and a queue
// of QUEUE_DEPTH addresses keep taking input meanwhile, until they fill.
`timescale 1ns / 1ps

module ipv6_address_to_text_top import ipv6txt_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  ipv6txt_addr_if.sink   in_chan,
  ipv6txt_char_if.source out_chan
);

  logic  push_valid;
  logic  push_ready;
  desc_t push_desc;
  logic  head_valid;
  logic  head_pop;
  desc_t head;

  // classification front
  ipv6txt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_ready     (in_chan.ready),
    .in_addr_high (in_chan.addr_high),
    .in_addr_low  (in_chan.addr_low),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_desc    (push_desc)
  );

  // decoupling queue
  ipv6txt_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .pop_valid  (head_valid),
    .pop        (head_pop),
    .pop_desc   (head)
  );

  // text back end
  ipv6txt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_char   (out_chan.out_char),
    .out_last   (out_chan.is_last)
  );

endmodule

/* verif/ipv6_address_to_text_top_tb.sv */
// ipv6_address_to_text_top_tb: self-checking bench for the ipv6 address to text formatter,
// with an in-bench text predictor, a scoreboard class and random handshake pacing
// depends on ipv6txt_pkg, ipv6txt_if and ipv6_address_to_text_top
`timescale 1ns / 1ps

module ipv6_address_to_text_top_tb import ipv6txt_pkg::*; ();

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_A    = 7'h61;
  localparam int unsigned       N_DIRECTED = 20;
  localparam int unsigned       N_RANDOM   = 200;
  localparam int unsigned       DRAIN_CYC  = 8;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  // expected text for every accepted address, checked one character at a time
  class ipv6_text_board;
    text_char_t  expected_text[$];
    int unsigned errors;
    int unsigned n_addresses;
    int unsigned n_chars;
    int unsigned n_compressed;

    function new();
      errors       = 0;
      n_addresses  = 0;
      n_chars      = 0;
      n_compressed = 0;
    endfunction

    task report(string what);
      $display("%0t mismatch: %s", $time, what);
      errors++;
    endtask

    function logic [CHAR_W-1:0] digit_char(logic [3:0] nib);
      return (nib < 4'd10) ? ASCII_ZERO + CHAR_W'(nib) : ASCII_A + CHAR_W'(nib - 4'd10);
    endfunction

    // format one address into compressed text and queue its characters
    function void note_address(logic [HALF_W-1:0] hi, logic [HALF_W-1:0] lo);
      logic [GRP_W-1:0]  grp [N_GRP];
      logic [CHAR_W-1:0] txt [$];
      logic [3:0]        nib;
      int                best_start, best_len, cur_start, cur_len, g, d;
      bit                started;
      text_char_t        tc;
      for (g = 0; g < 4; g++) begin
        grp[g]     = hi[HALF_W-1-GRP_W*g -: GRP_W];
        grp[g + 4] = lo[HALF_W-1-GRP_W*g -: GRP_W];
      end
      // longest zero run, earliest one on a tie
      best_start = -1;
      best_len   = 0;
      cur_start  = -1;
      cur_len    = 0;
      for (g = 0; g < N_GRP; g++) begin
        if (grp[g] == '0) begin
          if (cur_start < 0) begin
            cur_start = g;
            cur_len   = 0;
          end
          cur_len++;
          if (cur_len > best_len) begin
            best_start = cur_start;
            best_len   = cur_len;
          end
        end else begin
          cur_start = -1;
        end
      end
      if (best_len < 2) best_start = -1;
      if (best_start >= 0) n_compressed++;
      // build the text
      g = 0;
      while (g < N_GRP) begin
        if (g == best_start) begin
          if (g == 0) txt.push_back(CH_COLON);
          txt.push_back(CH_COLON);
          g += best_len;
        end else begin
          started = 1'b0;
          for (d = 3; d >= 0; d--) begin
            nib = grp[g][4*d +: 4];
            if (nib != 4'h0 || started || d == 0) begin
              started = 1'b1;
              txt.push_back(digit_char(nib));
            end
          end
          if (g < N_GRP - 1) txt.push_back(CH_COLON);
          g++;
        end
      end
      foreach (txt[i]) begin
        tc.ch   = txt[i];
        tc.last = (i == txt.size() - 1);
        expected_text.push_back(tc);
      end
      n_addresses++;
    endfunction

    // compare one output beat with the oldest expected character
    task check_char(logic [CHAR_W-1:0] ch, logic last);
      text_char_t exp_c;
      if (expected_text.size() == 0) begin
        report($sformatf("unexpected character '%c' last=%0b", ch, last));
        return;
      end
      exp_c = expected_text.pop_front();
      n_chars++;
      if (ch !== exp_c.ch)
        report($sformatf("char got '%c' (%h) want '%c' (%h)", ch, ch, exp_c.ch, exp_c.ch));
      if (last !== exp_c.last)
        report($sformatf("is_last got %0b want %0b on '%c'", last, exp_c.last, exp_c.ch));
    endtask
  endclass

  logic clk;
  logic rst_n;

  ipv6txt_addr_if in_chan ();
  ipv6txt_char_if out_chan ();

  ipv6_address_to_text_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  ipv6_text_board board = new();

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // directed addresses: extremes, run placement, ties, lone zeros, digit lengths
  localparam logic [127:0] DIRECTED [N_DIRECTED] = '{
    128'h0000_0000_0000_0000_0000_0000_0000_0000,
    128'hffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff,
    128'h0000_0000_0000_0000_0000_0000_0000_0001,
    128'h0001_0000_0000_0000_0000_0000_0000_0000,
    128'h2001_0db8_0000_0000_0000_0000_0002_0001,
    128'h2001_0db8_0000_0001_0001_0001_0001_0001,
    128'h0001_0000_0000_0002_0000_0000_0003_0004,
    128'h0001_0000_0002_0000_0000_0000_0003_0004,
    128'h0000_0001_0000_0001_0000_0001_0000_0001,
    128'h0001_0010_0100_1000_000f_00f0_0f00_f000,
    128'h0000_0000_0001_0000_0000_0000_0000_0000,
    128'h0000_0000_0000_0000_0000_0000_0001_0000,
    128'h0000_0000_0000_abcd_0000_0000_0000_0000,
    128'hfe80_0000_0000_0000_0202_b3ff_fe1e_8329,
    128'h1234_5678_9abc_def0_1234_5678_9abc_def0,
    128'h5555_5555_5555_5555_aaaa_aaaa_aaaa_aaaa,
    128'haaaa_aaaa_aaaa_aaaa_5555_5555_5555_5555,
    128'h0000_0000_ffff_ffff_ffff_ffff_0000_0000,
    128'hffff_0000_ffff_0000_ffff_0000_0000_ffff,
    128'h0000_0001_0000_0000_0001_0000_0000_0001
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random back-pressure on the character channel
  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // monitor: note accepted addresses, check accepted characters
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready)
        board.note_address(in_chan.addr_high, in_chan.addr_low);
      if (out_chan.valid && out_chan.ready)
        board.check_char(out_chan.out_char, out_chan.is_last);
    end
  end

  // one address beat, with random idle cycles ahead of it
  task automatic send_address(logic [127:0] addr);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.addr_high <= addr[127:64];
    in_chan.addr_low  <= addr[63:0];
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // random address, biased towards zero groups and short digit strings
  function automatic logic [127:0] random_address();
    logic [127:0] a;
    int           start, len;
    if ($urandom_range(0, 4) == 0)
      return {$urandom, $urandom, $urandom, $urandom};
    for (int g = 0; g < N_GRP; g++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: a[127-GRP_W*g -: GRP_W] = '0;
        4:          a[127-GRP_W*g -: GRP_W] = 16'hffff;
        5:          a[127-GRP_W*g -: GRP_W] = GRP_W'($urandom_range(1, 15));
        6:          a[127-GRP_W*g -: GRP_W] = GRP_W'($urandom_range(16, 255));
        7:          a[127-GRP_W*g -: GRP_W] = GRP_W'($urandom_range(256, 4095));
        default:    a[127-GRP_W*g -: GRP_W] = GRP_W'($urandom_range(1, 65535));
      endcase
    end
    // sometimes force a long zero run at a random place
    if ($urandom_range(0, 3) == 0) begin
      start = $urandom_range(0, N_GRP - 2);
      len   = $urandom_range(2, N_GRP - start);
      for (int g = start; g < start + len; g++) a[127-GRP_W*g -: GRP_W] = '0;
    end
    return a;
  endfunction

  // stimulus and end of run
  initial begin
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.addr_high <= '0;
    in_chan.addr_low  <= '0;
    send_idle_pct      = 36;
    recv_stall_pct     = 71;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // phase one: slow receiver, directed then random
    foreach (DIRECTED[i]) send_address(DIRECTED[i]);
    repeat (N_RANDOM / 3) send_address(random_address());
    // phase two: slow sender
    send_idle_pct  = 71;
    recv_stall_pct = 36;
    repeat (N_RANDOM / 3) send_address(random_address());
    // phase three: full rate on both sides
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (N_RANDOM - 2 * (N_RANDOM / 3)) send_address(random_address());
    in_chan.valid <= 1'b0;

    // drain, then a few more cycles to catch stray characters
    while (board.expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("run covered %0d addresses, %0d with a compressed zero run",
             board.n_addresses, board.n_compressed);
    $display("%0d characters checked under three pacing mixes, %0d mismatches",
             board.n_chars, board.errors);
    if (board.errors == 0) begin
      $display("[ipv6_address_to_text_top] OK");
    end else begin
      $display("[ipv6_address_to_text_top] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d characters outstanding", board.expected_text.size());
    $display("[ipv6_address_to_text_top] ERROR");
    $finish;
  end

endmodule

/* files.f */
hdl/ipv6txt_pkg.sv
hdl/ipv6txt_if.sv
hdl/ipv6txt_front.sv
hdl/ipv6txt_fifo.sv
hdl/ipv6txt_back.sv
hdl/ipv6_address_to_text_top.sv
verif/ipv6_address_to_text_top_tb.sv
